[rtl/ssrf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrf_pkg
// shared constants and types for the spi slave register file
// ----------------------------------------------------------------------------
package ssrf_pkg;

    localparam int STD_REG_COUNT = 47;
    localparam int EXT_REG_COUNT = 64;
    localparam int ADDR_W        = 6;
    localparam int BYTE_W        = 8;

    localparam logic [ADDR_W-1:0] ESCAPE_ADDR  = 6'h2f;
    localparam logic [ADDR_W-1:0] STROBE_FIRST = 6'h30;
    localparam logic [ADDR_W-1:0] STROBE_LAST  = 6'h3d;

    typedef enum logic [2:0] {
        MODE_READY        = 3'd0,
        MODE_SINGLE_READ  = 3'd1,
        MODE_SINGLE_WRITE = 3'd2,
        MODE_BURST_READ   = 3'd3,
        MODE_BURST_WRITE  = 3'd4,
        MODE_EXT_HEADER   = 3'd5
    } t_mode;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_bank_req;

endpackage
`default_nettype wire

[rtl/ssrf_bank.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrf_bank
// register bank memory, one write and one registered read per cycle, with
// per-entry valid bits so that unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
module ssrf_bank #(
    parameter int DEPTH = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire ssrf_pkg::t_bank_req       i_req,
    output logic [ssrf_pkg::BYTE_W-1:0]    o_rdata
);
    import ssrf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [BYTE_W-1:0] r_rdata;
    logic              r_rd_ok;

    logic          w_in_range;
    logic          r_in_range;
    logic [AW-1:0] widx;
    logic [AW-1:0] ridx;

    assign widx       = i_req.waddr[AW-1:0];
    assign ridx       = i_req.raddr[AW-1:0];
    assign w_in_range = ({1'b0, i_req.waddr} < (ADDR_W + 1)'(DEPTH));
    assign r_in_range = ({1'b0, i_req.raddr} < (ADDR_W + 1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_req.we && w_in_range) begin
            mem[widx] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_req.we && w_in_range) begin
                r_valid[widx] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_ok <= r_in_range && r_valid[ridx];
            end
        end
    end

    // out of range or never written reads as zero
    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule
`default_nettype wire

[rtl/spi_slave_register_file.sv]
`timescale 1ns / 1ps
`default_nettype none
// output: the result of an accepted pin sample is registered and shown in the next cycle
// throughput: one sample per cycle while the output is not held; a bank read issued at a byte boundary
//   lands in the output shifter in the following cycle, before the next edge
// reset: synchronous, active low; clears control state, the status byte and
//   the valid bits of both banks, so every register reads zero at once
// ----------------------------------------------------------------------------
// spi_slave_register_file
// oversampled spi mode 0 slave with standard and extended register banks
// ----------------------------------------------------------------------------
module spi_slave_register_file (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [0] sclk, [1] ss_n, [2] mosi
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [0] miso, [1] byte_done
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata     // status_byte
);
    import ssrf_pkg::*;

    logic              r_last_clk, n_last_clk;
    logic [2:0]        r_bitpos, n_bitpos;
    logic [BYTE_W-1:0] r_shift_in, n_shift_in;
    logic [BYTE_W-1:0] r_shift_out, n_shift_out;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_mode             r_mode, n_mode;
    logic              r_ext, n_ext;
    logic              r_miso, n_miso;
    logic [BYTE_W-1:0] r_status;
    logic              r_load, n_load;
    logic              r_load_ext, n_load_ext;
    logic              r_m_valid, n_m_valid;
    logic              r_m_miso, n_m_miso;
    logic              r_m_done, n_m_done;

    t_bank_req         std_req, ext_req;
    logic [BYTE_W-1:0] std_rdata, ext_rdata;

    logic              accept;
    logic              sclk, ss_n, mosi;
    logic [BYTE_W-1:0] sin;
    logic [ADDR_W-1:0] hdr_addr;
    logic [ADDR_W:0]   count;
    logic [ADDR_W:0]   a_ext;
    logic [ADDR_W:0]   a_next;
    logic              a_ok;
    logic              step_ok;
    logic              done;

    assign sclk = s_axis_tdata[0];
    assign ss_n = s_axis_tdata[1];
    assign mosi = s_axis_tdata[2];

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign count   = r_ext ? (ADDR_W + 1)'(EXT_REG_COUNT) : (ADDR_W + 1)'(STD_REG_COUNT);
    assign a_ext   = {1'b0, r_addr};
    assign a_next  = a_ext + 1'b1;
    assign a_ok    = a_ext < count;
    assign step_ok = a_next < count;

    always_comb begin
        n_last_clk = r_last_clk;
        n_bitpos   = r_bitpos;
        n_shift_in = r_shift_in;
        n_shift_out = r_load ? (r_load_ext ? ext_rdata : std_rdata) : r_shift_out;
        n_addr     = r_addr;
        n_mode     = r_mode;
        n_ext      = r_ext;
        n_miso     = r_miso;
        n_load     = 1'b0;
        n_load_ext = r_load_ext;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_miso   = r_m_miso;
        n_m_done   = r_m_done;
        std_req    = '0;
        ext_req    = '0;
        done       = 1'b0;
        sin        = r_shift_in | (BYTE_W'(mosi) << r_bitpos);
        hdr_addr   = sin[ADDR_W-1:0];

        std_req.waddr = r_addr;
        std_req.wdata = sin;
        ext_req.waddr = r_addr;
        ext_req.wdata = sin;

        if (accept) begin
            if (ss_n) begin
                n_mode      = MODE_READY;
                n_addr      = '0;
                n_ext       = 1'b0;
                n_shift_out = r_status;
                n_shift_in  = '0;
                n_bitpos    = 3'd7;
            end else if (sclk && !r_last_clk) begin
                n_miso = r_shift_out[r_bitpos];
                if (r_bitpos == 3'd0) begin
                    done     = 1'b1;
                    n_bitpos = 3'd7;
                    unique case (r_mode)
                        MODE_READY: begin
                            if ({1'b0, hdr_addr} < (ADDR_W + 1)'(STD_REG_COUNT)) begin
                                n_addr = hdr_addr;
                                if (sin[7]) begin
                                    std_req.re    = 1'b1;
                                    std_req.raddr = hdr_addr;
                                    n_load        = 1'b1;
                                    n_load_ext    = 1'b0;
                                    n_mode = sin[6] ? MODE_BURST_READ : MODE_SINGLE_READ;
                                end else begin
                                    n_shift_out = r_status;
                                    n_mode = sin[6] ? MODE_BURST_WRITE : MODE_SINGLE_WRITE;
                                end
                            end else if (hdr_addr == ESCAPE_ADDR) begin
                                n_mode = MODE_EXT_HEADER;
                                n_ext  = 1'b1;
                            end else if (hdr_addr >= STROBE_FIRST && hdr_addr <= STROBE_LAST) begin
                                n_mode      = MODE_READY;
                                n_addr      = '0;
                                n_ext       = 1'b0;
                                n_shift_out = r_status;
                            end
                        end
                        MODE_EXT_HEADER: begin
                            n_addr = hdr_addr;
                            if (sin[7]) begin
                                ext_req.re    = 1'b1;
                                ext_req.raddr = hdr_addr;
                                n_load        = 1'b1;
                                n_load_ext    = 1'b1;
                                n_mode = sin[6] ? MODE_BURST_READ : MODE_SINGLE_READ;
                            end else begin
                                n_shift_out = r_status;
                                n_mode = sin[6] ? MODE_BURST_WRITE : MODE_SINGLE_WRITE;
                            end
                        end
                        MODE_BURST_READ: begin
                            // saturate at the last register, then reread it
                            if (step_ok) begin
                                n_addr = a_next[ADDR_W-1:0];
                            end
                            n_load     = 1'b1;
                            n_load_ext = r_ext;
                            if (r_ext) begin
                                ext_req.re    = 1'b1;
                                ext_req.raddr = step_ok ? a_next[ADDR_W-1:0] : r_addr;
                            end else begin
                                std_req.re    = 1'b1;
                                std_req.raddr = step_ok ? a_next[ADDR_W-1:0] : r_addr;
                            end
                        end
                        MODE_BURST_WRITE: begin
                            if (a_ok) begin
                                std_req.we = !r_ext;
                                ext_req.we = r_ext;
                                if (step_ok) begin
                                    n_addr = a_next[ADDR_W-1:0];
                                end
                            end
                        end
                        MODE_SINGLE_WRITE: begin
                            if (a_ok) begin
                                std_req.we = !r_ext;
                                ext_req.we = r_ext;
                            end
                            n_mode      = MODE_READY;
                            n_addr      = '0;
                            n_ext       = 1'b0;
                            n_shift_out = r_status;
                        end
                        default: begin
                            n_mode      = MODE_READY;
                            n_addr      = '0;
                            n_ext       = 1'b0;
                            n_shift_out = r_status;
                        end
                    endcase
                    n_shift_in = '0;
                end else begin
                    n_bitpos   = r_bitpos - 3'd1;
                    n_shift_in = sin;
                end
            end
            n_last_clk = sclk;
            n_m_valid  = 1'b1;
            n_m_miso   = n_miso;
            n_m_done   = done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_clk  <= 1'b0;
            r_bitpos    <= 3'd7;
            r_shift_in  <= '0;
            r_shift_out <= '0;
            r_addr      <= '0;
            r_mode      <= MODE_READY;
            r_ext       <= 1'b0;
            r_miso      <= 1'b0;
            r_status    <= '0;
            r_load      <= 1'b0;
            r_load_ext  <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_last_clk  <= n_last_clk;
            r_bitpos    <= n_bitpos;
            r_shift_in  <= n_shift_in;
            r_shift_out <= n_shift_out;
            r_addr      <= n_addr;
            r_mode      <= n_mode;
            r_ext       <= n_ext;
            r_miso      <= n_miso;
            r_load      <= n_load;
            r_load_ext  <= n_load_ext;
            r_m_valid   <= n_m_valid;
            if (i_cfg_we) begin
                r_status <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_miso <= n_m_miso;
        r_m_done <= n_m_done;
    end

    ssrf_bank #(
        .DEPTH (STD_REG_COUNT)
    ) u_std_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (std_req),
        .o_rdata (std_rdata)
    );

    ssrf_bank #(
        .DEPTH (EXT_REG_COUNT)
    ) u_ext_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ext_req),
        .o_rdata (ext_rdata)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_done, r_m_miso};

endmodule
`default_nettype wire

[bench/tb_spi_slave_register_file.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_slave_register_file
// streams oversampled spi pin samples into the slave and checks every
// miso / byte_done reply against a cycle-free model of the shifters,
// the access modes and both register banks
// ----------------------------------------------------------------------------
module tb_spi_slave_register_file;
    import ssrf_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int TOTAL_ITEMS  = 1750;
    localparam int READ_BIT     = 7;
    localparam int BURST_BIT    = 6;
    localparam logic [ADDR_W-1:0] FIFO_FIRST = 6'h3e;
    localparam logic [ADDR_W-1:0] FIFO_LAST  = 6'h3f;

    typedef struct packed {
        logic miso;
        logic byte_done;
    } t_pin_reply;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [0] sclk, [1] ss_n, [2] mosi
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [0] miso, [1] byte_done
    logic       i_cfg_we      = 1'b0;
    logic [7:0] i_cfg_wdata   = 8'h00;   // status_byte

    // model of the slave
    logic [7:0] status_q;
    logic [7:0] rx_shift;
    logic [7:0] tx_shift;
    logic [7:0] std_bank [64];
    logic [7:0] ext_bank [64];
    logic       last_sclk;
    logic       ext_sel;
    logic       miso_now;
    logic [2:0] bit_idx;
    logic [5:0] cur_addr;
    t_mode      mode_now;

    t_pin_reply replies_due [$];
    t_pin_reply reply_head;
    logic [7:0] frame_q [$];

    bit pace_random  = 1'b0;
    int hold_request = 0;
    int stall_left   = 0;
    int error_count  = 0;
    int samples_sent = 0;
    int frames_sent  = 0;
    int bytes_seen   = 0;
    int status_writes = 0;

    spi_slave_register_file dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int bank_size();
        return ext_sel ? EXT_REG_COUNT : STD_REG_COUNT;
    endfunction

    function automatic logic [7:0] bank_read(input logic [5:0] a);
        return ext_sel ? ext_bank[a] : std_bank[a];
    endfunction

    function automatic void bank_write(input logic [5:0] a, input logic [7:0] d);
        if (ext_sel) begin
            ext_bank[a] = d;
        end else begin
            std_bank[a] = d;
        end
    endfunction

    function automatic void back_to_ready();
        mode_now = MODE_READY;
        cur_addr = '0;
        ext_sel  = 1'b0;
        tx_shift = status_q;
        rx_shift = '0;
    endfunction

    function automatic void reset_model();
        int i;
        status_q  = '0;
        last_sclk = 1'b0;
        bit_idx   = 3'd7;
        miso_now  = 1'b0;
        for (i = 0; i < 64; i++) begin
            std_bank[i] = '0;
            ext_bank[i] = '0;
        end
        back_to_ready();
    endfunction

    function automatic void open_access(input logic [7:0] hdr);
        cur_addr = hdr[ADDR_W-1:0];
        if (hdr[READ_BIT]) begin
            tx_shift = (int'(cur_addr) < bank_size()) ? bank_read(cur_addr) : 8'h00;
            mode_now = hdr[BURST_BIT] ? MODE_BURST_READ : MODE_SINGLE_READ;
        end else begin
            tx_shift = status_q;
            mode_now = hdr[BURST_BIT] ? MODE_BURST_WRITE : MODE_SINGLE_WRITE;
        end
    endfunction

    function automatic void decode_byte();
        logic [5:0] a6;
        int         a;
        a6 = rx_shift[ADDR_W-1:0];
        a  = int'(cur_addr);
        case (mode_now)
            MODE_READY: begin
                if (int'(a6) < STD_REG_COUNT) begin
                    open_access(rx_shift);
                end else if (a6 == ESCAPE_ADDR) begin
                    mode_now = MODE_EXT_HEADER;
                    ext_sel  = 1'b1;
                end else if (a6 >= STROBE_FIRST && a6 <= STROBE_LAST) begin
                    back_to_ready();
                end
                // fifo addresses leave the block in ready untouched
            end
            MODE_SINGLE_READ: begin
                back_to_ready();
            end
            MODE_SINGLE_WRITE: begin
                if (a < bank_size()) bank_write(cur_addr, rx_shift);
                back_to_ready();
            end
            MODE_BURST_READ: begin
                // address sticks at the last register
                if (a + 1 < bank_size()) a++;
                cur_addr = 6'(a);
                if (a < bank_size()) tx_shift = bank_read(cur_addr);
            end
            MODE_BURST_WRITE: begin
                if (a < bank_size()) begin
                    bank_write(cur_addr, rx_shift);
                    if (a + 1 < bank_size()) a++;
                    cur_addr = 6'(a);
                end
            end
            MODE_EXT_HEADER: begin
                open_access(rx_shift);
            end
            default: begin
                back_to_ready();
            end
        endcase
    endfunction

    function automatic t_pin_reply predict_pin_sample(input logic sclk, input logic ss_n,
                                                      input logic mosi);
        t_pin_reply r;
        r.byte_done = 1'b0;
        if (ss_n) begin
            back_to_ready();
            bit_idx = 3'd7;
        end else if (sclk && !last_sclk) begin
            miso_now = tx_shift[bit_idx];
            if (mosi) rx_shift[bit_idx] = 1'b1;
            if (bit_idx == 3'd0) begin
                decode_byte();
                bit_idx     = 3'd7;
                rx_shift    = '0;
                r.byte_done = 1'b1;
            end else begin
                bit_idx = bit_idx - 3'd1;
            end
        end
        last_sclk = sclk;
        r.miso = miso_now;
        return r;
    endfunction

    function automatic logic coin();
        return $urandom_range(0, 1) != 0;
    endfunction

    // no gap unless pacing is random; then mostly none, sometimes a short one, rarely a long pause
    function automatic int pick_gap();
        int r;
        if (!pace_random) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] header(input logic rd, input logic burst,
                                          input logic [5:0] addr);
        logic [7:0] h;
        h = {2'b00, addr};
        h[READ_BIT]  = rd;
        h[BURST_BIT] = burst;
        return h;
    endfunction

    task automatic send_pins(input logic sclk, input logic ss_n, input logic mosi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b00000, mosi, ss_n, sclk};
        do @(posedge i_clk); while (!s_axis_tready);
        replies_due.push_back(predict_pin_sample(sclk, ss_n, mosi));
        samples_sent++;
    endtask

    // one spi bit: low phase then a rising edge, each held for a few samples
    task automatic shift_bit(input logic value);
        int lows;
        int highs;
        lows  = pace_random ? $urandom_range(1, 3) : 1;
        highs = pace_random ? $urandom_range(1, 3) : 1;
        repeat (lows) send_pins(1'b0, 1'b0, value);
        send_pins(1'b1, 1'b0, value);
        repeat (highs - 1) send_pins(1'b1, 1'b0, coin());
    endtask

    // shifts frame_q out msb first, optionally cut short, then deselects
    task automatic send_frame(input int cut_bits);
        int total;
        int k;
        total = frame_q.size() * 8;
        if (cut_bits >= 0 && cut_bits < total) total = cut_bits;
        for (k = 0; k < total; k++) shift_bit(frame_q[k / 8][7 - (k % 8)]);
        repeat ($urandom_range(1, 3)) send_pins(coin(), 1'b1, coin());
        frames_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_status(input logic [7:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        status_q = value;
        status_writes++;
    endtask

    task automatic test_strobes_and_fifo();
        frame_q.delete();
        frame_q.push_back(header(1'b0, 1'b0, STROBE_FIRST));
        frame_q.push_back(header(1'b1, 1'b1, STROBE_LAST));
        frame_q.push_back(header(1'b1, 1'b0, FIFO_FIRST));
        frame_q.push_back(header(1'b0, 1'b1, FIFO_LAST));
        frame_q.push_back(header(1'b0, 1'b0, 6'd5));
        frame_q.push_back(8'h5a);
        send_frame(-1);
    endtask

    task automatic test_single_access();
        frame_q.delete();
        frame_q.push_back(header(1'b0, 1'b0, 6'd0));
        frame_q.push_back(8'hff);
        send_frame(-1);
        frame_q.delete();
        frame_q.push_back(header(1'b0, 1'b0, 6'(STD_REG_COUNT - 1)));
        frame_q.push_back(8'h01);
        send_frame(-1);
        // single read falls back to ready, so the third byte is a new header
        frame_q.delete();
        frame_q.push_back(header(1'b1, 1'b0, 6'd0));
        frame_q.push_back(8'h00);
        frame_q.push_back(header(1'b0, 1'b0, STROBE_FIRST));
        send_frame(-1);
        frame_q.delete();
        frame_q.push_back(header(1'b1, 1'b0, 6'(STD_REG_COUNT - 1)));
        frame_q.push_back(8'hff);
        send_frame(-1);
    endtask

    task automatic test_burst_saturation();
        frame_q.delete();
        frame_q.push_back(header(1'b0, 1'b1, 6'(STD_REG_COUNT - 3)));
        frame_q.push_back(8'h11);
        frame_q.push_back(8'h22);
        frame_q.push_back(8'h33);
        frame_q.push_back(8'h44);
        frame_q.push_back(8'h55);
        send_frame(-1);
        frame_q.delete();
        frame_q.push_back(header(1'b1, 1'b1, 6'(STD_REG_COUNT - 4)));
        repeat (5) frame_q.push_back(8'h00);
        send_frame(-1);
    endtask

    task automatic test_extended_bank();
        frame_q.delete();
        frame_q.push_back(header(1'b0, 1'b0, ESCAPE_ADDR));
        frame_q.push_back(header(1'b0, 1'b0, 6'd63));
        frame_q.push_back(8'hc3);
        send_frame(-1);
        frame_q.delete();
        frame_q.push_back(header(1'b1, 1'b1, ESCAPE_ADDR));
        frame_q.push_back(header(1'b0, 1'b1, 6'd61));
        frame_q.push_back(8'ha1);
        frame_q.push_back(8'ha2);
        frame_q.push_back(8'ha3);
        frame_q.push_back(8'ha4);
        send_frame(-1);
        frame_q.delete();
        frame_q.push_back(header(1'b0, 1'b1, ESCAPE_ADDR));
        frame_q.push_back(header(1'b1, 1'b1, 6'd59));
        repeat (6) frame_q.push_back(8'hff);
        send_frame(-1);
        // extended header with the upper address bits set
        frame_q.delete();
        frame_q.push_back(header(1'b1, 1'b0, ESCAPE_ADDR));
        frame_q.push_back(header(1'b1, 1'b0, 6'h3f));
        frame_q.push_back(8'h00);
        send_frame(-1);
    endtask

    task automatic test_deselect_cases();
        frame_q.delete();
        frame_q.push_back(header(1'b1, 1'b0, 6'(STD_REG_COUNT - 1)));
        send_frame(3);
        // clock edges while deselected must be ignored
        send_pins(1'b0, 1'b1, 1'b1);
        send_pins(1'b1, 1'b1, 1'b0);
        send_pins(1'b0, 1'b1, 1'b1);
        send_pins(1'b1, 1'b1, 1'b1);
        frame_q.delete();
        frame_q.push_back(header(1'b0, 1'b1, 6'd10));
        frame_q.push_back(8'h96);
        send_frame(12);
        frame_q.delete();
        frame_q.push_back(header(1'b1, 1'b0, 6'd10));
        frame_q.push_back(8'h00);
        send_frame(-1);
    endtask

    task automatic test_output_hold();
        pace_random = 1'b0;
        hold_request = 400;
        frame_q.delete();
        frame_q.push_back(header(1'b1, 1'b1, 6'd0));
        repeat (10) frame_q.push_back(8'h00);
        send_frame(-1);
    endtask

    task automatic random_frame();
        int         kind;
        int         n;
        int         i;
        int         cut;
        logic [5:0] a;
        frame_q.delete();
        kind = $urandom_range(0, 99);
        cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 23) : -1;
        a    = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(40, STD_REG_COUNT - 1))
                                           : 6'($urandom_range(0, STD_REG_COUNT - 1));
        if (kind < 8) begin
            // line noise, mostly selected
            n = $urandom_range(4, 40);
            for (i = 0; i < n; i++) send_pins(coin(), $urandom_range(0, 3) == 0, coin());
            return;
        end
        if (kind < 50) begin
            frame_q.push_back(header(coin(), coin(), a));
        end else if (kind < 75) begin
            frame_q.push_back(header(coin(), coin(), ESCAPE_ADDR));
            a = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(56, 63)) : 6'($urandom());
            frame_q.push_back(header(coin(), coin(), a));
        end else if (kind < 88) begin
            frame_q.push_back(header(coin(), coin(),
                                     6'($urandom_range(STROBE_FIRST, STROBE_LAST))));
            frame_q.push_back(header(coin(), coin(), a));
        end else begin
            frame_q.push_back(header(coin(), coin(), coin() ? FIFO_FIRST : FIFO_LAST));
            frame_q.push_back(header(coin(), coin(), a));
        end
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) frame_q.push_back(8'($urandom()));
        send_frame(cut);
    endtask

    task automatic test_random_traffic(input int sample_count);
        int stop_at;
        stop_at = samples_sent + sample_count;
        while (samples_sent < stop_at) begin
            pace_random = ($urandom_range(0, 4) != 0);
            random_frame();
        end
    endtask

    // receiver: random stalls plus the long hold requested by the hold test
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end else if (stall_left == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: reply with nothing expected, actual miso=%b byte_done=%b",
                         $time, m_axis_tdata[0], m_axis_tdata[1]);
                error_count++;
            end else begin
                reply_head = replies_due.pop_front();
                if (m_axis_tdata[0] !== reply_head.miso) begin
                    $display("%0t: miso expected %b actual %b",
                             $time, reply_head.miso, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[1] !== reply_head.byte_done) begin
                    $display("%0t: byte_done expected %b actual %b",
                             $time, reply_head.byte_done, m_axis_tdata[1]);
                    error_count++;
                end
                if (m_axis_tdata[1] === 1'b1) bytes_seen++;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_model();
        @(posedge i_clk);

        write_status(8'hff);
        test_strobes_and_fifo();
        test_single_access();
        test_burst_saturation();
        test_extended_bank();
        test_deselect_cases();

        write_status(8'h00);
        test_output_hold();

        // random traffic fills up the rest of the sample budget
        write_status(8'ha5);
        test_random_traffic((TOTAL_ITEMS - samples_sent) / 5);
        write_status(8'h01);
        test_random_traffic((TOTAL_ITEMS - samples_sent) / 4);
        write_status(8'h80);
        test_random_traffic((TOTAL_ITEMS - samples_sent) / 3);
        write_status(8'($urandom()));
        test_random_traffic((TOTAL_ITEMS - samples_sent) / 2);
        write_status(8'hff);
        test_random_traffic(TOTAL_ITEMS - samples_sent);

        wait_idle();
        $display("run covered %0d pin samples in %0d frames, %0d completed bytes",
                 samples_sent, frames_sent, bytes_seen);
        $display("status byte set %0d times, single and burst access to both banks",
                 status_writes);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
